// ===== sv/nwt_pkg.sv =====
`timescale 1ns / 1ps
package nwt_pkg;

  localparam int NumGroups = 4;
  localparam int SlotsPerGroup = 5;
  localparam int NumSlots = NumGroups * SlotsPerGroup;

  typedef logic [3:0] digit_t;
  typedef logic [4:0] word_t;

  localparam word_t W_ZERO     = 5'd0;
  localparam word_t W_TEN      = 5'd10;
  localparam word_t W_TWENTY   = 5'd20;
  localparam word_t W_HUNDRED  = 5'd28;
  localparam word_t W_THOUSAND = 5'd29;
  localparam word_t W_MILLION  = 5'd30;
  localparam word_t W_BILLION  = 5'd31;

  typedef struct packed {
    logic [NumSlots-1:0]        mask;
    word_t [NumSlots-1:0]       code;
  } tok_entry_t;

  typedef struct packed {
    logic       valid;
    tok_entry_t data;
  } fifo_rd_t;

endpackage

// ===== sv/nwt_if.sv =====
`timescale 1ns / 1ps
interface nwt_in_if;
  import nwt_pkg::*;
  logic   valid;
  logic   ready;
  digit_t digit_11;
  digit_t digit_10;
  digit_t digit_9;
  digit_t digit_8;
  digit_t digit_7;
  digit_t digit_6;
  digit_t digit_5;
  digit_t digit_4;
  digit_t digit_3;
  digit_t digit_2;
  digit_t digit_1;
  digit_t digit_0;

  modport source (output valid, digit_11, digit_10, digit_9, digit_8, digit_7, digit_6,
                  digit_5, digit_4, digit_3, digit_2, digit_1, digit_0, input ready);
  modport sink (input valid, digit_11, digit_10, digit_9, digit_8, digit_7, digit_6,
                digit_5, digit_4, digit_3, digit_2, digit_1, digit_0, output ready);
endinterface

interface nwt_out_if;
  import nwt_pkg::*;
  logic  valid;
  logic  ready;
  word_t word_code;
  logic  last_word;

  modport source (output valid, word_code, last_word, input ready);
  modport sink (input valid, word_code, last_word, output ready);
endinterface

// ===== sv/nwt_front.sv =====
`timescale 1ns / 1ps
module nwt_front
  import nwt_pkg::*;
(
  nwt_in_if.sink     in_ch,
  input  logic       fifo_full,
  output logic       push,
  output tok_entry_t push_data
);

  digit_t [NumGroups*3-1:0] dig;

  assign dig = {in_ch.digit_11, in_ch.digit_10, in_ch.digit_9,
                in_ch.digit_8, in_ch.digit_7, in_ch.digit_6,
                in_ch.digit_5, in_ch.digit_4, in_ch.digit_3,
                in_ch.digit_2, in_ch.digit_1, in_ch.digit_0};

  assign in_ch.ready = !fifo_full;
  assign push        = in_ch.valid && !fifo_full;

  always_comb begin
    digit_t h, t, o;
    int     b;
    tok_entry_t e;
    e = '0;
    for (int g = 0; g < NumGroups; g++) begin
      h = dig[NumGroups*3-1 - g*3];
      t = dig[NumGroups*3-2 - g*3];
      o = dig[NumGroups*3-3 - g*3];
      b = g * SlotsPerGroup;
      if (h >= 4'd1 && h <= 4'd9) begin
        e.mask[b]     = 1'b1;
        e.code[b]     = {1'b0, h};
        e.mask[b + 1] = 1'b1;
        e.code[b + 1] = W_HUNDRED;
      end
      if (t == 4'd1) begin
        if (o <= 4'd9) begin
          e.mask[b + 2] = 1'b1;
          e.code[b + 2] = W_TEN + {1'b0, o};
        end
      end else begin
        if (t >= 4'd2 && t <= 4'd9) begin
          e.mask[b + 2] = 1'b1;
          e.code[b + 2] = W_TWENTY + {1'b0, t} - 5'd2;
        end
        if (o >= 4'd1 && o <= 4'd9) begin
          e.mask[b + 3] = 1'b1;
          e.code[b + 3] = {1'b0, o};
        end
      end
      if (g < NumGroups - 1 && |e.mask[b +: SlotsPerGroup]) begin
        e.mask[b + 4] = 1'b1;
        e.code[b + 4] = (g == 0) ? W_BILLION : ((g == 1) ? W_MILLION : W_THOUSAND);
      end
    end
    if (e.mask == '0) begin
      e.mask[0] = 1'b1;
      e.code[0] = W_ZERO;
    end
    push_data = e;
  end

endmodule

// ===== sv/nwt_fifo.sv =====
`timescale 1ns / 1ps
module nwt_fifo
  import nwt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tok_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output fifo_rd_t   rd
);

  tok_entry_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign rd.valid = (count_r != 2'd0);
  assign rd.data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + 1'b1;
    rd_ptr_nxt = rd_ptr_r + 1'b1;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop)  rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== sv/nwt_back.sv =====
`timescale 1ns / 1ps
module nwt_back
  import nwt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_rd_t   rd,
  output logic       pop,
  nwt_out_if.source  out_ch
);

  logic                cur_valid_r, cur_valid_nxt;
  logic [NumSlots-1:0] cur_mask_r, cur_mask_nxt;
  word_t [NumSlots-1:0] cur_code_r;
  logic                out_valid_r;
  word_t               out_word_r;
  logic                out_last_r;

  logic                adv, emit, last;
  logic [NumSlots-1:0] lsb, rest;
  word_t               sel;

  assign lsb  = cur_mask_r & (~cur_mask_r + NumSlots'(1));
  assign rest = cur_mask_r & ~lsb;
  assign last = (rest == '0);
  assign adv  = !out_valid_r || out_ch.ready;
  assign emit = cur_valid_r && adv;
  assign pop  = rd.valid && (!cur_valid_r || (emit && last));

  always_comb begin
    sel = '0;
    for (int i = 0; i < NumSlots; i++) begin
      sel = sel | ({5{lsb[i]}} & cur_code_r[i]);
    end
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_mask_nxt  = cur_mask_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      cur_mask_nxt  = rd.data.mask;
    end else if (emit) begin
      cur_valid_nxt = !last;
      cur_mask_nxt  = rest;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.word_code = out_word_r;
  assign out_ch.last_word = out_last_r;

  always_ff @(posedge clk) begin
    if (pop) cur_code_r <= rd.data.code;
    cur_mask_r <= cur_mask_nxt;
    if (emit) begin
      out_word_r <= sel;
      out_last_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      if (adv) out_valid_r <= emit;
    end
  end

endmodule

// ===== sv/number_to_word_tokens.sv =====
`timescale 1ns / 1ps
// Spells a twelve-digit decimal number as English word tokens.
// in_ch: one request per number, digits digit_11 (most significant) down to
//   digit_0, accepted when valid and ready are both high.
// out_ch: one word token per handshake, most significant word first;
//   last_word marks the final token of a number.
// A number yields 1 to 19 tokens. One token leaves per cycle from the
// output register while the receiver holds ready high, so the output
// port sets the throughput. A new request is taken every cycle while the
// two-entry queue between the classifier and the token sequencer has room.
// When the back end is free, the first token of a request passes from the
// queue entry through the sequencer register to the output register.
// Reset (synchronous, rst_n low) empties the queue, the sequencer and the
// output register. When the receiver holds ready low, the current token
// stays on out_ch, the sequencer holds, the queue fills, and in_ch.ready
// drops once both queue entries are taken.
module number_to_word_tokens
  import nwt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  nwt_in_if.sink    in_ch,
  nwt_out_if.source out_ch
);

  logic       fifo_full;
  logic       push;
  tok_entry_t push_data;
  logic       pop;
  fifo_rd_t   rd;

  nwt_front u_front (
    .in_ch     (in_ch),
    .fifo_full (fifo_full),
    .push      (push),
    .push_data (push_data)
  );

  nwt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .rd        (rd)
  );

  nwt_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd     (rd),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== sv/nwt_checker.sv =====
`timescale 1ns / 1ps
module nwt_checker
  import nwt_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input word_t word_code,
  input logic  last_word
);

  logic [4:0] tok_cnt_r;
  logic [2:0] pend_r;
  logic       in_acc, out_acc, done;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign done    = out_acc && last_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_cnt_r <= '0;
      pend_r    <= '0;
    end else begin
      if (out_acc) tok_cnt_r <= last_word ? 5'd0 : tok_cnt_r + 5'd1;
      pend_r <= pend_r + 3'(in_acc) - 3'(done);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(word_code) && $stable(last_word))
    else $error("token changed while stalled");

  a_max_tokens: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && tok_cnt_r == 5'd18 |-> last_word)
    else $error("more than nineteen tokens for one number");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("token without an accepted request");

  a_zero_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && word_code == W_ZERO |-> last_word && tok_cnt_r == 5'd0)
    else $error("zero token not alone");

endmodule

bind number_to_word_tokens nwt_checker u_nwt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .word_code (out_ch.word_code),
  .last_word (out_ch.last_word)
);

// ===== tb/number_to_word_tokens_tb.sv =====
`timescale 1ns / 1ps
module number_to_word_tokens_tb;
  import nwt_pkg::*;

  localparam int NumRandom = 240;
  localparam int CalmTail = 60;
  localparam int CycleLimit = 200000;
  localparam int NumDirected = 22;

  localparam word_t WordOne = 5'd1;
  localparam word_t WordNine = 5'd9;
  localparam word_t WordNineteen = W_TEN + 5'd9;
  localparam word_t WordNinety = W_TWENTY + 5'd7;
  localparam word_t ScaleWord [3] = '{W_BILLION, W_MILLION, W_THOUSAND};

  typedef struct packed {
    word_t code;
    logic  last;
  } word_tok_t;

  typedef struct packed {
    logic [47:0]     num;
    int              n_words;
    word_t [0:3]     words;
  } num_row_t;

  // n_words of zero: tokens come from spell_number
  num_row_t directed_rows [NumDirected] = '{
    '{48'h000000000000, 1, '{W_ZERO, W_ZERO, W_ZERO, W_ZERO}},
    '{48'hFFFFFFFFFFFF, 1, '{W_ZERO, W_ZERO, W_ZERO, W_ZERO}},
    '{48'h000000000001, 1, '{WordOne, W_ZERO, W_ZERO, W_ZERO}},
    '{48'h000000000010, 1, '{W_TEN, W_ZERO, W_ZERO, W_ZERO}},
    '{48'h000000000019, 1, '{WordNineteen, W_ZERO, W_ZERO, W_ZERO}},
    '{48'h00000000001A, 1, '{W_ZERO, W_ZERO, W_ZERO, W_ZERO}},
    '{48'h0000000000F0, 1, '{W_ZERO, W_ZERO, W_ZERO, W_ZERO}},
    '{48'h000000000A00, 1, '{W_ZERO, W_ZERO, W_ZERO, W_ZERO}},
    '{48'h000000000090, 1, '{WordNinety, W_ZERO, W_ZERO, W_ZERO}},
    '{48'h000000000100, 2, '{WordOne, W_HUNDRED, W_ZERO, W_ZERO}},
    '{48'h000000001000, 2, '{WordOne, W_THOUSAND, W_ZERO, W_ZERO}},
    '{48'h000001000000, 2, '{WordOne, W_MILLION, W_ZERO, W_ZERO}},
    '{48'h001000000000, 2, '{WordOne, W_BILLION, W_ZERO, W_ZERO}},
    '{48'h100000000000, 3, '{WordOne, W_HUNDRED, W_BILLION, W_ZERO}},
    '{48'h000000009000, 2, '{WordNine, W_THOUSAND, W_ZERO, W_ZERO}},
    '{48'h999999999999, 0, '{W_ZERO, W_ZERO, W_ZERO, W_ZERO}},
    '{48'h123456789012, 0, '{W_ZERO, W_ZERO, W_ZERO, W_ZERO}},
    '{48'h1A1B9C0F0E00, 0, '{W_ZERO, W_ZERO, W_ZERO, W_ZERO}},
    '{48'h0001F0000115, 0, '{W_ZERO, W_ZERO, W_ZERO, W_ZERO}},
    '{48'h00B000D00007, 0, '{W_ZERO, W_ZERO, W_ZERO, W_ZERO}},
    '{48'h919918917916, 0, '{W_ZERO, W_ZERO, W_ZERO, W_ZERO}},
    '{48'h2A32B5C7D8E9, 0, '{W_ZERO, W_ZERO, W_ZERO, W_ZERO}}
  };

  logic clk;
  logic rst_n;
  nwt_in_if  in_ch ();
  nwt_out_if out_ch ();

  number_to_word_tokens DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  word_tok_t expected_words[$];
  int mismatch_count = 0;
  int tokens_checked = 0;
  int numbers_sent = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void spell_number(input logic [47:0] num);
    word_tok_t words[$];
    digit_t h;
    digit_t t;
    digit_t o;
    int start;
    for (int g = 0; g < NumGroups; g++) begin
      h = num[47-12*g -: 4];
      t = num[43-12*g -: 4];
      o = num[39-12*g -: 4];
      start = words.size();
      if (h >= 1 && h <= 9) begin
        words.push_back('{code: word_t'(h), last: 1'b0});
        words.push_back('{code: W_HUNDRED, last: 1'b0});
      end
      if (t == 1) begin
        if (o <= 9) words.push_back('{code: word_t'(W_TEN + o), last: 1'b0});
      end else begin
        if (t >= 2 && t <= 9)
          words.push_back('{code: word_t'(W_TWENTY + t - 5'd2), last: 1'b0});
        if (o >= 1 && o <= 9) words.push_back('{code: word_t'(o), last: 1'b0});
      end
      if (words.size() != start && g < NumGroups - 1)
        words.push_back('{code: ScaleWord[g], last: 1'b0});
    end
    if (words.size() == 0) words.push_back('{code: W_ZERO, last: 1'b0});
    words[words.size()-1].last = 1'b1;
    foreach (words[k]) expected_words.push_back(words[k]);
  endfunction

  function automatic logic [47:0] rand_number();
    logic [47:0] num;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) begin
      case (mode)
        0: num[4*i +: 4] = 4'($urandom_range(0, 15));
        1: num[4*i +: 4] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(10, 15))
                                                        : 4'($urandom_range(0, 9));
        default: num[4*i +: 4] = 4'($urandom_range(0, 9));
      endcase
    end
    for (int g = 0; g < NumGroups; g++) begin
      case ($urandom_range(0, 5))
        0: num[12*g +: 12] = '0;
        1: num[12*g+4 +: 4] = 4'd1;
        default: ;
      endcase
    end
    // zero-pad the top to get shorter numbers
    if ($urandom_range(0, 3) == 0) num = num >> (4 * $urandom_range(1, 11));
    if ($urandom_range(0, 29) == 0) num = '0;
    return num;
  endfunction

  task automatic send_number(input logic [47:0] num, input int n_words,
                             input word_t [0:3] words);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.digit_11 <= num[47:44];
    in_ch.digit_10 <= num[43:40];
    in_ch.digit_9  <= num[39:36];
    in_ch.digit_8  <= num[35:32];
    in_ch.digit_7  <= num[31:28];
    in_ch.digit_6  <= num[27:24];
    in_ch.digit_5  <= num[23:20];
    in_ch.digit_4  <= num[19:16];
    in_ch.digit_3  <= num[15:12];
    in_ch.digit_2  <= num[11:8];
    in_ch.digit_1  <= num[7:4];
    in_ch.digit_0  <= num[3:0];
    do @(posedge clk); while (!in_ch.ready);
    if (n_words == 0) begin
      spell_number(num);
    end else begin
      for (int k = 0; k < n_words; k++)
        expected_words.push_back('{code: words[k], last: (k == n_words - 1)});
    end
    numbers_sent++;
  endtask

  // receiver drops ready in bursts while idle_on is set
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    word_tok_t tok;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tokens_checked++;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected token code=%0d last=%0b",
                                  out_ch.word_code, out_ch.last_word));
      end else begin
        tok = expected_words.pop_front();
        if (out_ch.word_code !== tok.code)
          report_mismatch($sformatf("word_code got %0d want %0d",
                                    out_ch.word_code, tok.code));
        if (out_ch.last_word !== tok.last)
          report_mismatch($sformatf("last_word got %0b want %0b",
                                    out_ch.last_word, tok.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d tokens outstanding",
               cycle_count, expected_words.size());
      $display("FAIL number_to_word_tokens");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    out_ch.ready   = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.digit_11 = '0;
    in_ch.digit_10 = '0;
    in_ch.digit_9  = '0;
    in_ch.digit_8  = '0;
    in_ch.digit_7  = '0;
    in_ch.digit_6  = '0;
    in_ch.digit_5  = '0;
    in_ch.digit_4  = '0;
    in_ch.digit_3  = '0;
    in_ch.digit_2  = '0;
    in_ch.digit_1  = '0;
    in_ch.digit_0  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r])
      send_number(directed_rows[r].num, directed_rows[r].n_words, directed_rows[r].words);

    for (int i = 0; i < NumRandom; i++) begin
      idle_on = (i < NumRandom - CalmTail) && ((i / 25) % 3 != 2);
      send_number(rand_number(), 0, '{W_ZERO, W_ZERO, W_ZERO, W_ZERO});
    end
    in_ch.valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d numbers (%0d from the directed table), checked %0d word tokens",
             numbers_sent, NumDirected, tokens_checked);
    $display("Mismatches: %0d", mismatch_count);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("PASS number_to_word_tokens");
    end else begin
      $display("FAIL number_to_word_tokens");
    end
    $finish;
  end

endmodule

// ===== number_to_word_tokens.f =====
sv/nwt_pkg.sv
sv/nwt_if.sv
sv/nwt_front.sv
sv/nwt_fifo.sv
sv/nwt_back.sv
sv/number_to_word_tokens.sv
sv/nwt_checker.sv
tb/number_to_word_tokens_tb.sv
